>>> rtl/wsdf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the websocket frame deframer
// no dependencies

package wsdf_pkg;

   localparam int CFG_W              = 24;
   localparam int LIMIT_BITS_DEFAULT = 24;
   localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 24'd8388608;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef enum logic [2:0] {
      PH_HEAD0 = 3'd0,
      PH_HEAD1 = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_MASK  = 3'd4,
      PH_DATA  = 3'd5,
      PH_FAIL  = 3'd6
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       last;
      logic       empty;
      logic       err;
   } result_type;

endpackage

>>> rtl/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// websocket frame deframer: takes the received stream a byte per request on
// req_, emits unmasked payload, empty-frame and length-error results on rsp_
// limit register written through csr_wr_en / csr_wr_data
// one byte is taken per cycle while ready; the header, length and mask key bytes are
// parsed in a single pass between the parser state and the result register
// a result appears on rsp_ in the cycle after the byte that causes it
// header bytes produce no result, apart from the empty-frame and error cases
// req_tready is low only while a result is held and rsp_tready is low, so a
// stalled receiver holds back the stream, and a taken result frees the slot
// in the same cycle
// after an over-length frame is flagged every byte is dropped until reset
// reset clears the parser to expect the first header byte and restores the
// limit to its default; no clearing pass is needed
// depends on wsdf_pkg, wsdf_parser, wsdf_out_reg

module websocket_frame_deframer
   import wsdf_pkg::*;
#(
   parameter int LIMIT_BITS = LIMIT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // stream_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // data_byte
   output logic             rsp_tlast,   // last_of_frame
   output logic [7:0]       rsp_tuser,   // frame_opcode[3:0], empty_frame, length_error, zeros
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data  // max_payload_bytes
);

   localparam int KEEP_W = (LIMIT_BITS < CFG_W) ? LIMIT_BITS : CFG_W;

   logic [KEEP_W-1:0] limit_ff, limit_in;
   logic              accept;
   result_type        result;
   result_type        rsp_result;

   assign accept   = req_tvalid && req_tready;
   assign limit_in = csr_wr_en ? csr_wr_data[KEEP_W-1:0] : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MAX_PAYLOAD_RESET[KEEP_W-1:0];
      end else begin
         limit_ff <= limit_in;
      end
   end

   wsdf_parser #(
      .LIMIT_W (KEEP_W)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_tdata),
      .limit       (limit_ff),
      .result      (result)
   );

   wsdf_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .ready      (req_tready),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = rsp_result.data;
   assign rsp_tlast = rsp_result.last;
   assign rsp_tuser = {2'b00, rsp_result.err, rsp_result.empty, rsp_result.opcode};

endmodule

>>> rtl/wsdf_parser.sv
`timescale 1ns / 1ps
// per-byte header parser, length check and unmasking
// depends on wsdf_pkg

module wsdf_parser
   import wsdf_pkg::*;
#(
   parameter int LIMIT_W = LIMIT_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         stream_byte,
   input  logic [LIMIT_W-1:0] limit,
   output result_type         result
);

   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] KEY_LAST   = 3'd3;

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [63:0] len_ff, len_in;
   logic [2:0]  hcount_ff, hcount_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  mpos_ff, mpos_in;

   logic [6:0]  len7;
   logic        is_ext;
   logic [63:0] cand;
   logic        too_long;
   logic        ext_done;
   logic        mask_sel;
   logic        cand_zero;
   logic        len_zero;
   logic [7:0]  key_byte;

   assign len7      = stream_byte[6:0];
   assign is_ext    = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
   assign cand      = (phase_ff == PH_HEAD1) ? {57'd0, len7} : {len_ff[55:0], stream_byte};
   assign too_long  = cand > 64'(limit);
   assign ext_done  = hcount_ff == ((phase_ff == PH_EXT16) ? EXT16_LAST : EXT64_LAST);
   assign mask_sel  = (phase_ff == PH_HEAD1) ? stream_byte[7] : masked_ff;
   assign cand_zero = cand == 64'd0;
   assign len_zero  = len_ff == 64'd0;
   assign key_byte  = masked_ff ? key_ff[{~mpos_ff, 3'b000} +: 8] : 8'd0;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HEAD0: begin
            phase_in = PH_HEAD1;
         end
         PH_HEAD1, PH_EXT16, PH_EXT64: begin
            if (phase_ff == PH_HEAD1 && len7 == LEN_EXT16) begin
               phase_in = PH_EXT16;
            end else if (phase_ff == PH_HEAD1 && len7 == LEN_EXT64) begin
               phase_in = PH_EXT64;
            end else if (phase_ff == PH_HEAD1 || ext_done) begin
               if (too_long) begin
                  phase_in = PH_FAIL;
               end else if (mask_sel) begin
                  phase_in = PH_MASK;
               end else begin
                  phase_in = cand_zero ? PH_HEAD0 : PH_DATA;
               end
            end
         end
         PH_MASK: begin
            if (hcount_ff == KEY_LAST) begin
               phase_in = len_zero ? PH_HEAD0 : PH_DATA;
            end
         end
         PH_DATA: begin
            if (len_ff == 64'd1) begin
               phase_in = PH_HEAD0;
            end
         end
         default: begin
            phase_in = PH_FAIL;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      opcode_in     = opcode_ff;
      masked_in     = masked_ff;
      len_in        = len_ff;
      hcount_in     = hcount_ff;
      key_in        = key_ff;
      mpos_in       = mpos_ff;
      result        = '0;
      result.opcode = opcode_ff;
      case (phase_ff)
         PH_HEAD0: begin
            opcode_in = stream_byte[3:0];
         end
         PH_HEAD1, PH_EXT16, PH_EXT64: begin
            if (phase_ff == PH_HEAD1) begin
               masked_in = stream_byte[7];
               hcount_in = 3'd0;
               len_in    = is_ext ? 64'd0 : cand;
            end else begin
               len_in    = cand;
               if (!ext_done) begin
                  hcount_in = hcount_ff + 3'd1;
               end
            end
            if ((phase_ff == PH_HEAD1 && !is_ext) || (phase_ff != PH_HEAD1 && ext_done)) begin
               if (too_long) begin
                  result.valid = 1'b1;
                  result.err   = 1'b1;
               end else if (mask_sel) begin
                  hcount_in = 3'd0;
                  key_in    = 32'd0;
               end else begin
                  mpos_in = 2'd0;
                  if (cand_zero) begin
                     result.valid = 1'b1;
                     result.last  = 1'b1;
                     result.empty = 1'b1;
                  end
               end
            end
         end
         PH_MASK: begin
            key_in = {key_ff[23:0], stream_byte};
            if (hcount_ff == KEY_LAST) begin
               mpos_in = 2'd0;
               if (len_zero) begin
                  result.valid = 1'b1;
                  result.last  = 1'b1;
                  result.empty = 1'b1;
               end
            end else begin
               hcount_in = hcount_ff + 3'd1;
            end
         end
         PH_DATA: begin
            mpos_in      = mpos_ff + 2'd1;
            len_in       = len_ff - 64'd1;
            result.valid = 1'b1;
            result.data  = stream_byte ^ key_byte;
            result.last  = len_ff == 64'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD0;
         opcode_ff <= 4'd0;
         masked_ff <= 1'b0;
         len_ff    <= 64'd0;
         hcount_ff <= 3'd0;
         key_ff    <= 32'd0;
         mpos_ff   <= 2'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         len_ff    <= len_in;
         hcount_ff <= hcount_in;
         key_ff    <= key_in;
         mpos_ff   <= mpos_in;
      end
   end

endmodule

>>> rtl/wsdf_out_reg.sv
`timescale 1ns / 1ps
// result register on the response side, gives input ready
// depends on wsdf_pkg

module wsdf_out_reg
   import wsdf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp_result
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign ready      = !valid_ff || rsp_ready;
   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ready) begin
         valid_in = load && result.valid;
      end
      if (load) begin
         data_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
